[design/pre_pkg.sv]
// Shared types and constants of the pulse rate estimator.
`timescale 1ns / 1ps
`default_nettype none
package pre_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int TICK_W     = 16;
  localparam int DEN_W      = 20;
  localparam int NUM_W      = 28;
  localparam int BPM_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_CNT_W  = 5;

  typedef logic [SAMPLE_W-1:0]  sample_t;
  typedef logic [TICK_W-1:0]    tick_t;
  typedef logic [DEN_W-1:0]     den_t;
  typedef logic [NUM_W-1:0]     num_t;
  typedef logic [BPM_W-1:0]     bpm_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [DIV_CNT_W-1:0] div_cnt_t;

  localparam cfg_idx_t CFG_THRESHOLD    = 2'd0;
  localparam cfg_idx_t CFG_MIN_INTERVAL = 2'd1;
  localparam cfg_idx_t CFG_TICKS_PER_MIN = 2'd2;

  localparam tick_t    TICK_MAX      = '1;
  localparam bpm_t     BPM_MAX       = '1;
  localparam div_cnt_t DIV_LAST      = div_cnt_t'(NUM_W - 1);

  localparam sample_t RST_THRESHOLD    = 12'd2062;
  localparam tick_t   RST_MIN_INTERVAL = 16'd45;
  localparam tick_t   RST_TICKS_PER_MIN = 16'd6000;

  // Work item handed from the front end to the divider side.
  typedef struct packed {
    logic beat;
    den_t den;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_t;

endpackage
`default_nettype wire

[design/pulse_rate_estimator_top.sv]
// Top level of the pulse rate estimator: configuration registers, front end, queue, divider.
`timescale 1ns / 1ps
`default_nettype none
// Each sample yields one transfer on the result channel: beat and the rate in unsigned
// Q8.8 bpm (zero when no beat). The front end takes a sample per cycle while the queue
// has room. A non-beat result goes from the queue into the output register; a beat is
// popped into the restoring divider, which produces one quotient bit per cycle, and its
// quotient is then loaded into the output register. Nothing is popped while a beat is in
// the divider; other samples go at one per cycle while out_stall is low. Configuration
// writes are always taken (cfg_ready is tied high); unknown register indexes are ignored.
module pulse_rate_estimator_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  [pre_pkg::SAMPLE_W-1:0]       in_sample,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic                               out_beat,
  output logic [pre_pkg::BPM_W-1:0]          out_bpm_q8,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [pre_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [pre_pkg::CFG_DATA_W-1:0]     cfg_data
);

  pre_pkg::sample_t threshold_r, threshold_nxt;
  pre_pkg::tick_t   min_interval_r, min_interval_nxt;
  pre_pkg::tick_t   tpm_r, tpm_nxt;

  logic               in_accept;
  logic               q_push;
  logic               q_pop;
  pre_pkg::q_entry_t  q_push_data;
  pre_pkg::q_entry_t  q_head;
  pre_pkg::q_status_t q_status;

  assign cfg_ready = 1'b1;

  always_comb begin
    threshold_nxt    = threshold_r;
    min_interval_nxt = min_interval_r;
    tpm_nxt          = tpm_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pre_pkg::CFG_THRESHOLD:     threshold_nxt    = cfg_data[pre_pkg::SAMPLE_W-1:0];
        pre_pkg::CFG_MIN_INTERVAL:  min_interval_nxt = cfg_data[pre_pkg::TICK_W-1:0];
        pre_pkg::CFG_TICKS_PER_MIN: tpm_nxt          = cfg_data[pre_pkg::TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r    <= pre_pkg::RST_THRESHOLD;
      min_interval_r <= pre_pkg::RST_MIN_INTERVAL;
      tpm_r          <= pre_pkg::RST_TICKS_PER_MIN;
    end else begin
      threshold_r    <= threshold_nxt;
      min_interval_r <= min_interval_nxt;
      tpm_r          <= tpm_nxt;
    end
  end

  assign in_stall  = q_status.full;
  assign in_accept = in_valid && !in_stall;

  pre_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .sample       (in_sample),
    .threshold    (threshold_r),
    .min_interval (min_interval_r),
    .push         (q_push),
    .push_data    (q_push_data)
  );

  pre_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_status)
  );

  pre_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .ticks_per_minute (tpm_r),
    .head             (q_head),
    .q_status         (q_status),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_beat         (out_beat),
    .out_bpm_q8       (out_bpm_q8)
  );

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_status.empty)
    else $error("pop from empty queue");

  a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_status.full && q_status.empty))
    else $error("queue both full and empty");

  a_nobeat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_beat) |-> (out_bpm_q8 == '0))
    else $error("nonzero rate without beat");

endmodule
`default_nettype wire

[design/pre_queue.sv]
// Small FIFO between the beat detector and the rate divider.
`timescale 1ns / 1ps
`default_nettype none
module pre_queue #(
  parameter int DEPTH = 2
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  pre_pkg::q_entry_t    push_data,
  input  wire                  pop,
  output pre_pkg::q_entry_t    head,
  output pre_pkg::q_status_t   status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  pre_pkg::q_entry_t entry_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  assign head         = entry_r[rd_ptr_r];
  assign status.full  = (count_r == CNT_FULL);
  assign status.empty = (count_r == '0);

endmodule
`default_nettype wire

[design/pre_front.sv]
// Front end: takes samples, detects rising threshold crossings as beats, queues the divisor.
`timescale 1ns / 1ps
`default_nettype none
module pre_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 accept,
  input  pre_pkg::sample_t    sample,
  input  pre_pkg::sample_t    threshold,
  input  pre_pkg::tick_t      min_interval,
  output logic                push,
  output pre_pkg::q_entry_t   push_data
);

  pre_pkg::sample_t last_sample_r, last_sample_nxt;
  pre_pkg::tick_t   ticks_r, ticks_nxt;
  pre_pkg::tick_t   last_int_r, last_int_nxt;
  logic             beat;

  assign beat = (last_sample_r < threshold) && (sample >= threshold) &&
                (ticks_r > min_interval);

  // divisor = 6*interval + 4*previous interval
  assign push_data.beat = beat;
  assign push_data.den  = (pre_pkg::den_t'(ticks_r) << 2) +
                          (pre_pkg::den_t'(ticks_r) << 1) +
                          (pre_pkg::den_t'(last_int_r) << 2);
  assign push = accept;

  always_comb begin
    last_sample_nxt = last_sample_r;
    ticks_nxt       = ticks_r;
    last_int_nxt    = last_int_r;
    if (accept) begin
      last_sample_nxt = sample;
      if (beat) begin
        last_int_nxt = ticks_r;
        ticks_nxt    = pre_pkg::tick_t'(1);
      end else if (ticks_r != pre_pkg::TICK_MAX) begin
        ticks_nxt = ticks_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sample_r <= '0;
      ticks_r       <= '0;
      last_int_r    <= '0;
    end else begin
      last_sample_r <= last_sample_nxt;
      ticks_r       <= ticks_nxt;
      last_int_r    <= last_int_nxt;
    end
  end

endmodule
`default_nettype wire

[design/pre_back.sv]
// Back end: restoring divider for the Q8.8 rate and the registered result stage.
`timescale 1ns / 1ps
`default_nettype none
module pre_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  pre_pkg::tick_t      ticks_per_minute,
  input  pre_pkg::q_entry_t   head,
  input  pre_pkg::q_status_t  q_status,
  output logic                pop,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic                out_beat,
  output pre_pkg::bpm_t       out_bpm_q8
);

  pre_pkg::back_state_t state_r, state_nxt;

  logic [pre_pkg::DEN_W:0] rem_r, rem_nxt;
  pre_pkg::num_t           num_r, num_nxt;
  pre_pkg::num_t           quo_r, quo_nxt;
  pre_pkg::den_t           den_r, den_nxt;
  pre_pkg::div_cnt_t       cnt_r, cnt_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    out_beat_r, out_beat_nxt;
  pre_pkg::bpm_t           out_bpm_r, out_bpm_nxt;

  logic                      out_free;
  logic                      div_start;
  logic                      out_load;
  logic [pre_pkg::DEN_W:0]   rem_sh;
  logic [pre_pkg::DEN_W+1:0] diff;
  logic                      ge;
  pre_pkg::num_t             num_init;
  pre_pkg::bpm_t             quo_sat;

  assign out_free = !out_valid_r || !out_stall;

  // ticks_per_minute * 2560
  assign num_init = (pre_pkg::num_t'(ticks_per_minute) << 11) +
                    (pre_pkg::num_t'(ticks_per_minute) << 9);

  assign rem_sh = {rem_r[pre_pkg::DEN_W-1:0], num_r[pre_pkg::NUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_r};
  assign ge     = !diff[pre_pkg::DEN_W+1];

  assign quo_sat = (|quo_r[pre_pkg::NUM_W-1:pre_pkg::BPM_W]) ? pre_pkg::BPM_MAX
                                                              : quo_r[pre_pkg::BPM_W-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pre_pkg::BK_IDLE: begin
        if (!q_status.empty && out_free && head.beat) begin
          state_nxt = pre_pkg::BK_DIV;
        end
      end
      pre_pkg::BK_DIV: begin
        if (cnt_r == pre_pkg::DIV_LAST) begin
          state_nxt = pre_pkg::BK_DONE;
        end
      end
      pre_pkg::BK_DONE: begin
        if (out_free) begin
          state_nxt = pre_pkg::BK_IDLE;
        end
      end
      default: state_nxt = pre_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop          = 1'b0;
    div_start    = 1'b0;
    out_load     = 1'b0;
    out_beat_nxt = 1'b0;
    out_bpm_nxt  = '0;
    unique case (state_r)
      pre_pkg::BK_IDLE: begin
        pop       = !q_status.empty && out_free;
        div_start = pop && head.beat;
        out_load  = pop && !head.beat;
      end
      pre_pkg::BK_DIV: begin
      end
      pre_pkg::BK_DONE: begin
        out_load     = out_free;
        out_beat_nxt = 1'b1;
        out_bpm_nxt  = quo_sat;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rem_nxt = rem_r;
    num_nxt = num_r;
    quo_nxt = quo_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    if (div_start) begin
      rem_nxt = '0;
      num_nxt = num_init;
      quo_nxt = '0;
      den_nxt = head.den;
      cnt_nxt = '0;
    end else if (state_r == pre_pkg::BK_DIV) begin
      rem_nxt = ge ? diff[pre_pkg::DEN_W:0] : rem_sh;
      num_nxt = num_r << 1;
      quo_nxt = {quo_r[pre_pkg::NUM_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pre_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
    if (out_load) begin
      out_beat_r <= out_beat_nxt;
      out_bpm_r  <= out_bpm_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_beat   = out_beat_r;
  assign out_bpm_q8 = out_bpm_r;

endmodule
`default_nettype wire
